@@ hdl/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and controller/datapath handshake types for the
// first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // Heap geometry.
  localparam int HEAP_WORDS = 4096;
  localparam int WORD_BYTES = 4;
  localparam int ADDR_W     = $clog2(HEAP_WORDS);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int HDR_W      = LEN_W + 1;

  // Widths fixed by the request and result fields.
  localparam int CMD_W     = 2;
  localparam int COUNT_W   = 14;
  localparam int ETYPE_W   = 2;
  localparam int OFF_W     = 12;
  localparam int WORDS_W   = 14;
  localparam int FREE_W    = 12;
  localparam int BLK_W     = 13;
  localparam int CMP_W     = (LEN_W > WORDS_W) ? LEN_W : WORDS_W;
  localparam int BYTES_W   = COUNT_W + $clog2(WORD_BYTES) + 1;
  localparam int WSHIFT    = $clog2(WORD_BYTES);

  // Header of the single free block that fills the heap after reset.
  localparam logic [HDR_W-1:0] HDR_RESET = {LEN_W'(HEAP_WORDS), 1'b0};

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((COUNT_W + ETYPE_W + OFF_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OFF_W + FREE_W + BLK_W + 7) / 8) * 8;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_COALESCE = 2'd2,
    OP_NOP      = 2'd3
  } ffha_op_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic eval;
    logic split_wr;
    logic finish;
  } ffha_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic skip;
    logic walk_done;
    logic do_split;
    logic out_busy;
  } ffha_status_t;

endpackage

@@ hdl/ffha_ram.sv @@
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ffha_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for the allocator: takes a request, steps the header walk one
// memory read at a time and hands the result to the output register.
// ----------------------------------------------------------------------------
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ffha_status_t status_i,
  output ffha_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_SPLIT = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        if (status_i.skip) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (status_i.walk_done) begin
          state_d = status_i.do_split ? S_SPLIT : S_DONE;
        end else begin
          state_d = S_READ;
        end
      end
      S_SPLIT: begin
        cmd_o.split_wr = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/ffha_datapath.sv @@
// ----------------------------------------------------------------------------
// ffha_datapath
// Request registers, walk position, counters, header decode and the output
// register of the allocator. Drives the header memory ports.
// ----------------------------------------------------------------------------
module ffha_datapath
  import ffha_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffha_cmd_t           cmd_i,
  output ffha_status_t        status_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [COUNT_W-1:0]  element_count_i,
  input  logic [ETYPE_W-1:0]  element_type_i,
  input  logic [OFF_W-1:0]    block_offset_i,
  output logic                ram_we_o,
  output logic [ADDR_W-1:0]   ram_waddr_o,
  output logic [HDR_W-1:0]    ram_wdata_o,
  output logic                ram_re_o,
  output logic [ADDR_W-1:0]   ram_raddr_o,
  input  logic [HDR_W-1:0]    ram_rdata_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                res_status_o,
  output logic [OFF_W-1:0]    payload_offset_o,
  output logic [FREE_W-1:0]   free_word_total_o,
  output logic [BLK_W-1:0]    block_total_o
);

  ffha_op_e           op_q;
  logic [WORDS_W-1:0] words_q;
  logic [OFF_W-1:0]   off_q;
  logic [ADDR_W-1:0]  pos_q;
  logic [LEN_W-1:0]   rem_q;
  logic [ADDR_W-1:0]  run_head_q;
  logic [LEN_W-1:0]   run_len_q;
  logic               in_run_q;
  logic [FREE_W-1:0]  free_cnt_q;
  logic [BLK_W-1:0]   blk_cnt_q;
  logic               res_status_q;
  logic [OFF_W-1:0]   res_payload_q;
  logic               w0_q;
  logic               rd_zero_q;
  logic               out_valid_q;
  logic               out_status_q;
  logic [OFF_W-1:0]   out_payload_q;
  logic [FREE_W-1:0]  out_free_q;
  logic [BLK_W-1:0]   out_blk_q;

  logic [BYTES_W-1:0] req_bytes;
  logic [BYTES_W-1:0] req_words;
  logic [HDR_W-1:0]   hdr;
  logic [LEN_W-1:0]   len;
  logic               used;
  logic [LEN_W-1:0]   avail;
  logic               len_zero;
  logic               fit;
  logic [CMP_W-1:0]   rem_wide;
  logic [LEN_W-1:0]   rem;
  logic               split;
  logic [LEN_W:0]     next_pos;
  logic               walk_end;
  logic [LEN_W-1:0]   merged;
  logic [ADDR_W-1:0]  free_idx;
  logic               off_bad;
  logic [ADDR_W-1:0]  split_addr;
  logic [LEN_W-1:0]   taken_len;

  // Request size in words: bytes rounded up to whole words.
  always_comb begin
    req_bytes = BYTES_W'(element_count_i);
    if (!element_type_i[0]) begin
      req_bytes = req_bytes << WSHIFT;
    end
    req_words = (req_bytes + BYTES_W'(WORD_BYTES - 1)) >> WSHIFT;
  end

  // Header decode; word 0 reads as the reset block until it is written.
  assign hdr      = (rd_zero_q && !w0_q) ? HDR_RESET : ram_rdata_i;
  assign len      = hdr[HDR_W-1:1];
  assign used     = hdr[0];
  assign avail    = len - LEN_W'(1);
  assign len_zero = (len == '0);
  assign fit      = !used && !len_zero && (CMP_W'(avail) >= CMP_W'(words_q));
  assign rem_wide = CMP_W'(avail) - CMP_W'(words_q);
  assign rem      = rem_wide[LEN_W-1:0];
  assign split    = (rem >= LEN_W'(2));
  assign next_pos = (LEN_W+1)'(pos_q) + (LEN_W+1)'(len);
  assign walk_end = 32'(next_pos) >= 32'(HEAP_WORDS);
  assign merged   = run_len_q + len;
  assign taken_len = LEN_W'(32'(words_q) + 1);

  // Free target and its range check.
  assign free_idx   = ADDR_W'(off_q - OFF_W'(1));
  assign off_bad    = (off_q == '0) || (32'(off_q) > 32'(HEAP_WORDS));
  assign split_addr = ADDR_W'(32'(pos_q) + 32'(words_q) + 1);

  // Status toward the controller.
  always_comb begin
    status_o.skip      = (op_q == OP_NOP) || ((op_q == OP_FREE) && off_bad);
    status_o.out_busy  = out_valid_q && !out_ready_i;
    status_o.do_split  = (op_q == OP_ALLOC) && fit && split;
    status_o.walk_done = 1'b1;
    unique case (op_q)
      OP_ALLOC:    status_o.walk_done = len_zero || fit || walk_end;
      OP_COALESCE: status_o.walk_done = len_zero || walk_end;
      OP_FREE:     status_o.walk_done = 1'b1;
      OP_NOP:      status_o.walk_done = 1'b1;
      default:     status_o.walk_done = 1'b1;
    endcase
  end

  // Header memory ports.
  assign ram_re_o    = cmd_i.rd_en;
  assign ram_raddr_o = (op_q == OP_FREE) ? free_idx : pos_q;

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_q;
    ram_wdata_o = '0;
    if (cmd_i.split_wr) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = split_addr;
      ram_wdata_o = {rem_q, 1'b0};
    end else if (cmd_i.eval) begin
      unique case (op_q)
        OP_ALLOC: begin
          ram_we_o    = fit;
          ram_waddr_o = pos_q;
          ram_wdata_o = split ? {taken_len, 1'b1} : {len, 1'b1};
        end
        OP_FREE: begin
          ram_we_o    = 1'b1;
          ram_waddr_o = free_idx;
          ram_wdata_o = {len, 1'b0};
        end
        OP_COALESCE: begin
          ram_we_o    = !len_zero && !used && in_run_q;
          ram_waddr_o = run_head_q;
          ram_wdata_o = {merged, 1'b0};
        end
        OP_NOP: begin
          ram_we_o = 1'b0;
        end
        default: begin
          ram_we_o = 1'b0;
        end
      endcase
    end
  end

  // Word 0 tracking: reset marks it as holding the full-heap free block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_q <= 1'b0;
    end else if (ram_we_o && (ram_waddr_o == '0)) begin
      w0_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re_o) begin
      rd_zero_q <= (ram_raddr_o == '0);
    end
  end

  // Running counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_cnt_q <= FREE_W'(HEAP_WORDS - 1);
      blk_cnt_q  <= BLK_W'(1);
    end else if (cmd_i.eval) begin
      unique case (op_q)
        OP_ALLOC: begin
          if (fit && split) begin
            free_cnt_q <= free_cnt_q - FREE_W'(32'(words_q) + 1);
            blk_cnt_q  <= blk_cnt_q + BLK_W'(1);
          end else if (fit) begin
            free_cnt_q <= free_cnt_q - FREE_W'(avail);
          end
        end
        OP_FREE: begin
          free_cnt_q <= free_cnt_q + FREE_W'(avail);
        end
        OP_COALESCE: begin
          if (!len_zero && !used && in_run_q) begin
            blk_cnt_q <= blk_cnt_q - BLK_W'(1);
          end
        end
        OP_NOP: begin
          blk_cnt_q <= blk_cnt_q;
        end
        default: begin
          blk_cnt_q <= blk_cnt_q;
        end
      endcase
    end
  end

  // Request registers, walk state and pending result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q          <= ffha_op_e'(command_i);
      words_q       <= WORDS_W'(req_words);
      off_q         <= block_offset_i;
      pos_q         <= '0;
      in_run_q      <= 1'b0;
      res_status_q  <= 1'b0;
      res_payload_q <= '0;
    end else if (cmd_i.eval) begin
      unique case (op_q)
        OP_ALLOC: begin
          if (fit) begin
            res_payload_q <= OFF_W'(32'(pos_q) + 1);
            rem_q         <= rem;
          end else if (len_zero || walk_end) begin
            res_status_q <= 1'b1;
          end else begin
            pos_q <= ADDR_W'(next_pos);
          end
        end
        OP_COALESCE: begin
          if (!len_zero) begin
            if (!used) begin
              if (in_run_q) begin
                run_len_q <= merged;
              end else begin
                in_run_q   <= 1'b1;
                run_head_q <= pos_q;
                run_len_q  <= len;
              end
            end else begin
              in_run_q <= 1'b0;
            end
            pos_q <= ADDR_W'(next_pos);
          end
        end
        OP_FREE: begin
          pos_q <= pos_q;
        end
        OP_NOP: begin
          pos_q <= pos_q;
        end
        default: begin
          pos_q <= pos_q;
        end
      endcase
    end
  end

  // Output register: holds a result until the downstream side takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q  <= res_status_q;
      out_payload_q <= res_payload_q;
      out_free_q    <= free_cnt_q;
      out_blk_q     <= blk_cnt_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign res_status_o      = out_status_q;
  assign payload_offset_o  = out_payload_q;
  assign free_word_total_o = out_free_q;
  assign block_total_o     = out_blk_q;

endmodule

@@ hdl/first_fit_heap_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit word heap allocator with in-band block headers, stream ports.
// ----------------------------------------------------------------------------
// One request is worked at a time, and every request returns one result.
// The cost is set by the header memory's single registered read port: each
// header visited by a walk is read in the read state, then decoded and
// updated in the eval state. An allocate or coalesce takes both states per
// header walked, plus the split state when an allocation splits its block;
// a free reads and decodes one header, and an unused command goes straight
// to the done state. The done state waits while the output register holds
// an untaken result; the controller then returns to idle for the next request.
// The output register lets a new request be accepted while a result still
// waits downstream. No clearing pass is needed after reset: only word 0 is
// defined, and a flag makes it read as the full-heap free block until written.
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // element_count [13:0], element_type [15:14], block_offset [27:16], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // command [1:0]
  input  logic [CMD_W-1:0]      s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // payload_offset [11:0], free_word_total [23:12], block_total [36:24], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // status [0]
  output logic                  m_axis_tuser_o
);

  ffha_cmd_t          cmd;
  ffha_status_t       status;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [HDR_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [HDR_W-1:0]   ram_rdata;
  logic [OFF_W-1:0]   payload_offset;
  logic [FREE_W-1:0]  free_word_total;
  logic [BLK_W-1:0]   block_total;

  // Sequencer.
  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  ffha_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .command_i         (s_axis_tuser_i),
    .element_count_i   (s_axis_tdata_i[COUNT_W-1:0]),
    .element_type_i    (s_axis_tdata_i[COUNT_W+ETYPE_W-1:COUNT_W]),
    .block_offset_i    (s_axis_tdata_i[COUNT_W+ETYPE_W+OFF_W-1:COUNT_W+ETYPE_W]),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .ram_re_o          (ram_re),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata),
    .out_ready_i       (m_axis_tready_i),
    .out_valid_o       (m_axis_tvalid_o),
    .res_status_o      (m_axis_tuser_o),
    .payload_offset_o  (payload_offset),
    .free_word_total_o (free_word_total),
    .block_total_o     (block_total)
  );

  // Header store.
  ffha_ram #(
    .WIDTH (HDR_W),
    .DEPTH (HEAP_WORDS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result packing.
  assign m_axis_tdata_o = OUT_DATA_W'({block_total, free_word_total, payload_offset});

  // A request is worked alone: no new request right after one is taken.
  a_one_at_a_time : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o
  ) else $error("request accepted while another is in progress");

  // A failed allocation never reports a payload offset.
  a_fail_no_payload : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (payload_offset == '0)
  ) else $error("failed allocation carries a payload offset");

  // The remainder header is written only right after a header decode.
  a_split_after_eval : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.split_wr |-> $past(cmd.eval)
  ) else $error("split write without a preceding header decode");

endmodule

@@ test/first_fit_heap_allocator_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit_test
// Runs a short table of allocate, free and coalesce requests from reset, then
// several hundred random requests, against a cycle-free software copy of the
// heap. Every reply is compared field by field with the copy's prediction or
// a hand-read one, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit_test;
  import ffha_pkg::*;

  // Element type codes of an allocate request.
  localparam logic [ETYPE_W-1:0] ET_INT  = 2'd0;
  localparam logic [ETYPE_W-1:0] ET_CHAR = 2'd1;
  localparam logic [ETYPE_W-1:0] ET_MINT = 2'd2;
  localparam logic [ETYPE_W-1:0] ET_BOOL = 2'd3;

  localparam int RANDOM_REQUESTS = 430;
  localparam int PAUSE_AT        = 200;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES    = 64;
  // A walk over every header of a fully split heap must fit under this limit.
  localparam int STALL_LIMIT     = 40000;

  typedef struct packed {
    logic              status;
    logic [OFF_W-1:0]  payload;
    logic [FREE_W-1:0] free_total;
    logic [BLK_W-1:0]  block_total;
  } heap_reply_t;

  typedef struct packed {
    ffha_op_e           op;
    logic [COUNT_W-1:0] cnt;
    logic [ETYPE_W-1:0] et;
    logic [OFF_W-1:0]   off;
    logic               typed;
    heap_reply_t        reply;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_valid;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [CMD_W-1:0]      s_tuser;
  logic                  m_ready;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  // Software copy of the heap.
  logic [HDR_W-1:0]  hdr_mem [HEAP_WORDS];
  bit                hdr_written [HEAP_WORDS];
  int                hdr_idx_q [$];
  logic [FREE_W-1:0] free_cnt;
  logic [BLK_W-1:0]  blocks_cnt;

  heap_reply_t reply_q [$];
  heap_reply_t got_reply;
  heap_reply_t want_reply;
  int          err_cnt      = 0;
  int          replies_seen = 0;
  int          stall_cycles = 0;
  int          burst_left   = 0;

  first_fit_heap_allocator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Applies one request to the heap copy and returns the reply it must give.
  function automatic heap_reply_t heap_apply(ffha_op_e op, logic [COUNT_W-1:0] cnt,
                                             logic [ETYPE_W-1:0] et, logic [OFF_W-1:0] off);
    heap_reply_t r;
    int unsigned nbytes, nwords, pos, len, rem, at, run_head, idx;
    bit          found, in_run;
    r = '0;
    case (op)
      OP_ALLOC: begin
        nbytes = cnt * ((et == ET_INT || et == ET_MINT) ? WORD_BYTES : 1);
        nwords = (nbytes + WORD_BYTES - 1) / WORD_BYTES;
        pos    = 0;
        found  = 1'b0;
        // First fit: walk the headers from word 0.
        while (!found && pos < HEAP_WORDS) begin
          len = hdr_mem[pos][HDR_W-1:1];
          if (len == 0) begin
            pos = HEAP_WORDS;
          end else if (!hdr_mem[pos][0] && len - 1 >= nwords) begin
            rem = len - 1 - nwords;
            if (rem >= 2) begin
              // Split off the tail as a new free block.
              at          = pos + 1 + nwords;
              hdr_mem[at] = HDR_W'(rem << 1);
              if (!hdr_written[at]) begin
                hdr_written[at] = 1'b1;
                hdr_idx_q.push_back(at);
              end
              blocks_cnt   = blocks_cnt + 1'b1;
              free_cnt     = free_cnt - FREE_W'(nwords + 1);
              hdr_mem[pos] = HDR_W'(((1 + nwords) << 1) | 1);
            end else begin
              free_cnt        = free_cnt - FREE_W'(len - 1);
              hdr_mem[pos][0] = 1'b1;
            end
            r.payload = OFF_W'(pos + 1);
            found     = 1'b1;
          end else begin
            pos = pos + len;
          end
        end
        r.status = !found;
      end
      OP_FREE: begin
        // Offset zero is ignored; the used bit is cleared without a check.
        if (off != 0) begin
          idx             = off - 1;
          hdr_mem[idx][0] = 1'b0;
          free_cnt        = free_cnt + FREE_W'(hdr_mem[idx][HDR_W-1:1] - 1);
        end
      end
      OP_COALESCE: begin
        pos      = 0;
        run_head = 0;
        in_run   = 1'b0;
        while (pos < HEAP_WORDS) begin
          len = hdr_mem[pos][HDR_W-1:1];
          if (len == 0) begin
            pos = HEAP_WORDS;
          end else begin
            if (!hdr_mem[pos][0]) begin
              if (in_run) begin
                hdr_mem[run_head] = HDR_W'((hdr_mem[run_head][HDR_W-1:1] + len) << 1);
                blocks_cnt        = blocks_cnt - 1'b1;
              end else begin
                in_run   = 1'b1;
                run_head = pos;
              end
            end else begin
              in_run = 1'b0;
            end
            pos = pos + len;
          end
        end
      end
      default: begin
      end
    endcase
    r.free_total  = free_cnt;
    r.block_total = blocks_cnt;
    return r;
  endfunction

  function automatic dir_row_t mk_row(ffha_op_e op, int cnt, logic [ETYPE_W-1:0] et, int off,
                                      bit typed, int st, int pl, int fr, int bl);
    dir_row_t row;
    row.op                = op;
    row.cnt               = COUNT_W'(cnt);
    row.et                = et;
    row.off               = OFF_W'(off);
    row.typed             = typed;
    row.reply.status      = st[0];
    row.reply.payload     = OFF_W'(pl);
    row.reply.free_total  = FREE_W'(fr);
    row.reply.block_total = BLK_W'(bl);
    return row;
  endfunction

  // Offers one request in the sender's burst pattern and books its reply.
  task automatic send_request(ffha_op_e op, logic [COUNT_W-1:0] cnt, logic [ETYPE_W-1:0] et,
                              logic [OFF_W-1:0] off, bit typed, heap_reply_t typed_reply);
    heap_reply_t want;
    int          gap;
    want = heap_apply(op, cnt, et, off);
    if (typed) want = typed_reply;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
      s_tdata <= $urandom;
      s_tuser <= CMD_W'($urandom);
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_tdata <= IN_DATA_W'({off, et, cnt});
    s_tuser <= op;
    @(posedge clk_i);
    while (s_axis_tready_o !== 1'b1) @(posedge clk_i);
    reply_q.push_back(want);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Compare every reply with the oldest booked one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      replies_seen <= replies_seen + 1;
      got_reply.status      = m_axis_tuser_o;
      got_reply.payload     = m_axis_tdata_o[OFF_W-1:0];
      got_reply.free_total  = m_axis_tdata_o[OFF_W +: FREE_W];
      got_reply.block_total = m_axis_tdata_o[OFF_W+FREE_W +: BLK_W];
      if (reply_q.size() == 0) begin
        $error("reply with none pending: status %0d payload %0d", got_reply.status,
               got_reply.payload);
        err_cnt++;
      end else begin
        want_reply = reply_q.pop_front();
        check_field("status", want_reply.status, got_reply.status);
        check_field("payload_offset", want_reply.payload, got_reply.payload);
        check_field("free_word_total", want_reply.free_total, got_reply.free_total);
        check_field("block_total", want_reply.block_total, got_reply.block_total);
      end
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("first_fit_heap_allocator_unit_test: errors");
      $finish;
    end
  end

  // Receiver: stall patterns that change after spans of random length, plus one long hold-off.
  initial begin
    int  mode, span;
    bit  held_off;
    held_off = 1'b0;
    m_ready  = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && replies_seen >= 60) begin
        held_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk_i);
          m_ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 48);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0:       m_ready <= 1'b1;
          1:       m_ready <= ($urandom_range(0, 3) != 0);
          2:       m_ready <= ($urandom_range(0, 3) == 0);
          default: m_ready <= ~m_ready;
        endcase
      end
    end
  end

  initial begin
    dir_row_t           dir_tab [$];
    dir_row_t           row;
    ffha_op_e           op;
    logic [COUNT_W-1:0] cnt;
    logic [ETYPE_W-1:0] et;
    logic [OFF_W-1:0]   off;
    int                 pick, idx;

    rst_ni  = 1'b0;
    s_valid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;

    // Heap copy after reset: one free block over the whole heap.
    foreach (hdr_mem[i]) begin
      hdr_mem[i]     = '0;
      hdr_written[i] = 1'b0;
    end
    hdr_mem[0]     = HDR_RESET;
    hdr_written[0] = 1'b1;
    hdr_idx_q.push_back(0);
    free_cnt   = FREE_W'(HEAP_WORDS - 1);
    blocks_cnt = BLK_W'(1);

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table; rows with typed = 1 carry a reply read off by hand.
    dir_tab.push_back(mk_row(OP_NOP,      0,     ET_INT,  0, 1, 0, 0, 4095, 1));
    dir_tab.push_back(mk_row(OP_ALLOC,    16380, ET_INT,  0, 1, 1, 0, 4095, 1));
    dir_tab.push_back(mk_row(OP_COALESCE, 0,     ET_INT,  0, 1, 0, 0, 4095, 1));
    dir_tab.push_back(mk_row(OP_FREE,     0,     ET_INT,  0, 1, 0, 0, 4095, 1));
    dir_tab.push_back(mk_row(OP_ALLOC,    0,     ET_INT,  0, 1, 0, 1, 4094, 2));
    dir_tab.push_back(mk_row(OP_ALLOC,    1,     ET_CHAR, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ALLOC,    3,     ET_BOOL, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ALLOC,    5,     ET_CHAR, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ALLOC,    4,     ET_MINT, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ALLOC,    16380, ET_CHAR, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_FREE,     0,     ET_INT,  2, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_FREE,     0,     ET_INT,  4, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_COALESCE, 0,     ET_INT,  0, 0, 0, 0, 0, 0));
    // Freeing a free block counts its words a second time.
    dir_tab.push_back(mk_row(OP_FREE,     0,     ET_INT,  2, 0, 0, 0, 0, 0));
    // Header left behind inside a merged block.
    dir_tab.push_back(mk_row(OP_FREE,     0,     ET_INT,  4, 0, 0, 0, 0, 0));
    // One word would remain, so the whole block is taken.
    dir_tab.push_back(mk_row(OP_ALLOC,    2,     ET_INT,  0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_FREE,     0,     ET_INT,  6, 0, 0, 0, 0, 0));
    // Exact fit, nothing remains.
    dir_tab.push_back(mk_row(OP_ALLOC,    8,     ET_CHAR, 0, 0, 0, 0, 0, 0));
    // Header-only block freed and reused by a zero-count request.
    dir_tab.push_back(mk_row(OP_FREE,     0,     ET_INT,  1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ALLOC,    0,     ET_BOOL, 0, 0, 0, 0, 0, 0));
    // Take the rest of the heap, then fail on a full heap.
    dir_tab.push_back(mk_row(OP_ALLOC,    4082,  ET_INT,  0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ALLOC,    0,     ET_INT,  0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_FREE,     0,     ET_INT,  14, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_COALESCE, 0,     ET_INT,  0, 0, 0, 0, 0, 0));

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      send_request(row.op, row.cnt, row.et, row.off, row.typed, row.reply);
    end

    // Random requests: mostly small allocations and frees of live blocks.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == PAUSE_AT) begin
        @(negedge clk_i);
        s_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge clk_i);
      end
      cnt  = COUNT_W'($urandom_range(0, 16380));
      et   = ETYPE_W'($urandom_range(0, 3));
      off  = OFF_W'($urandom_range(0, 4095));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        op   = OP_ALLOC;
        pick = $urandom_range(0, 99);
        if (pick < 70)      cnt = COUNT_W'($urandom_range(0, 40));
        else if (pick < 93) cnt = COUNT_W'($urandom_range(41, 700));
        else if (pick < 98) cnt = COUNT_W'($urandom_range(701, 3000));
      end else if (pick < 83) begin
        op  = OP_FREE;
        idx = hdr_idx_q[$urandom_range(0, hdr_idx_q.size() - 1)];
        repeat (6) begin
          if (!hdr_mem[idx][0]) idx = hdr_idx_q[$urandom_range(0, hdr_idx_q.size() - 1)];
        end
        off = OFF_W'(idx + 1);
      end else if (pick < 95) begin
        op = OP_COALESCE;
      end else begin
        op = OP_NOP;
      end
      send_request(op, cnt, et, off, 1'b0, '0);
    end

    @(negedge clk_i);
    s_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("first_fit_heap_allocator_unit_test: clean");
    end else begin
      $display("first_fit_heap_allocator_unit_test: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/ffha_pkg.sv
hdl/ffha_ram.sv
hdl/ffha_ctrl.sv
hdl/ffha_datapath.sv
hdl/first_fit_heap_allocator_unit.sv
test/first_fit_heap_allocator_unit_test.sv
